FILE: rtl/olte_pkg.sv
package olte_pkg;

   // List geometry.
   localparam int DEPTH   = 64;
   localparam int ENTRY_W = 32;
   localparam int IDX_W   = $clog2(DEPTH);

   // Field widths of the request and response beats.
   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int MIDX_W   = 6;
   localparam int COUNT_W  = 7;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_SET    = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef logic [ENTRY_W-1:0] entry_type;

   // Request token that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic                valid;
      logic [OP_W-1:0]     op;
      logic [POS_W-1:0]    pos;
      entry_type           value;
      logic [COUNT_W-1:0]  count;
      logic                hit;
      logic [MIDX_W-1:0]   match_idx;
      entry_type           rd;
   } tok_type;

   // One response beat.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic                found;
      logic [MIDX_W-1:0]   match_index;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } ctl_state_type;

endpackage

FILE: rtl/olte_req_if.sv
interface olte_req_if;
   logic                         valid;
   logic                         ready;
   logic [olte_pkg::OP_W-1:0]    op;
   logic [olte_pkg::POS_W-1:0]   position;
   logic [olte_pkg::VALUE_W-1:0] value;

   modport source (output valid, op, position, value, input ready);
   modport sink   (input valid, op, position, value, output ready);
endinterface

FILE: rtl/olte_rsp_if.sv
interface olte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [olte_pkg::STATUS_W-1:0] status;
   logic [olte_pkg::VALUE_W-1:0]  read_value;
   logic                          found;
   logic [olte_pkg::MIDX_W-1:0]   match_index;
   logic [olte_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, status, read_value, found, match_index, entry_count,
                   input ready);
   modport sink   (input valid, status, read_value, found, match_index, entry_count,
                   output ready);
endinterface

FILE: rtl/olte_cell.sv
// One list slot. It acts on the token passing through and hands it on.
module olte_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [olte_pkg::IDX_W-1:0] index,
   input  olte_pkg::tok_type          tok_in,
   input  olte_pkg::entry_type        next_entry,
   output olte_pkg::tok_type          tok_out,
   output olte_pkg::entry_type        entry_out
);

   olte_pkg::entry_type entry_ff, entry_in;
   olte_pkg::tok_type   tok_ff, tok_in_next;
   logic                in_range, at_pos, at_end, equal;

   always_comb begin
      in_range    = olte_pkg::COUNT_W'(index) < tok_in.count;
      at_pos      = olte_pkg::COUNT_W'(index) == olte_pkg::COUNT_W'(tok_in.pos);
      at_end      = olte_pkg::COUNT_W'(index) == tok_in.count;
      equal       = entry_ff == tok_in.value;
      entry_in    = entry_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         case (tok_in.op)
            olte_pkg::OP_APPEND: begin
               if (at_end) entry_in = tok_in.value;
            end
            olte_pkg::OP_REMOVE: begin
               // From the first match on, every live slot pulls in its neighbor.
               if (in_range && (tok_in.hit || equal)) begin
                  entry_in        = next_entry;
                  tok_in_next.hit = 1'b1;
               end
            end
            olte_pkg::OP_GET: begin
               if (in_range && at_pos) tok_in_next.rd = entry_ff;
            end
            olte_pkg::OP_SET: begin
               if (in_range && at_pos) entry_in = tok_in.value;
            end
            olte_pkg::OP_FIND: begin
               if (in_range && !tok_in.hit && equal) begin
                  tok_in_next.hit       = 1'b1;
                  tok_in_next.match_idx = olte_pkg::MIDX_W'(index);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out   = tok_ff;
   assign entry_out = entry_ff;

endmodule

FILE: rtl/ordered_list_table_engine_unit.sv
// Ordered list table engine: a bounded ordered list of up to DEPTH entries.
// Requests arrive on the req channel (op, position, value) and each one
// produces exactly one response beat on the rsp channel (status, read_value,
// found, match_index, entry_count). A beat moves when valid and ready are both
// high at a rising clock edge.
// The list is held in a row of DEPTH cells. An accepted request becomes a
// token that walks down the row one cell per cycle; each cell compares,
// writes, shifts or reads its own entry as the token passes. Only one
// token is in the row at a time: no new request is taken until the response
// has left the row, whatever the operation.
// A finished response goes to the rsp output register. If that register
// still holds an untaken beat, the new response waits in a holding register,
// and the next request is only taken once the holding register has drained;
// a request can be accepted while a response waits in the output register.
// Synchronous reset empties the list (entry count zero), drops any token in
// flight and clears the response valid. The entry storage itself is not
// cleared: only entries below the count are ever read.
module ordered_list_table_engine_unit (
   input logic        clock,
   input logic        reset,
   olte_req_if.sink   req,
   olte_rsp_if.source rsp
);

   olte_pkg::ctl_state_type state_ff, state_in;
   logic [olte_pkg::COUNT_W-1:0] fill_count_ff, fill_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   olte_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   olte_pkg::rsp_type       pend_ff, pend_in;
   olte_pkg::rsp_type       result;
   olte_pkg::tok_type       tok_chain [0:olte_pkg::DEPTH];
   olte_pkg::entry_type     entry_row [0:olte_pkg::DEPTH-1];
   olte_pkg::tok_type       last_tok;
   logic                    accept, slot_free;

   assign req.ready = state_ff == olte_pkg::ST_IDLE;
   assign accept    = req.valid && req.ready;

   // Launch token: it carries the count as it stands when the walk begins.
   always_comb begin
      tok_chain[0]           = '0;
      tok_chain[0].valid     = accept;
      tok_chain[0].op        = req.op;
      tok_chain[0].pos       = req.position;
      tok_chain[0].value     = req.value[olte_pkg::ENTRY_W-1:0];
      tok_chain[0].count     = fill_count_ff;
   end

   for (genvar g = 0; g < olte_pkg::DEPTH; g++) begin : g_cell
      olte_pkg::entry_type next_entry;
      // The last slot has no upper neighbor; whatever it pulls in lies
      // above the shrunken count and is never read.
      if (g == olte_pkg::DEPTH - 1) begin : g_tail
         assign next_entry = entry_row[g];
      end else begin : g_body
         assign next_entry = entry_row[g+1];
      end

      olte_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .index      (olte_pkg::IDX_W'(g)),
         .tok_in     (tok_chain[g]),
         .next_entry (next_entry),
         .tok_out    (tok_chain[g+1]),
         .entry_out  (entry_row[g])
      );
   end

   assign last_tok = tok_chain[olte_pkg::DEPTH];

   // The token leaving the last cell has seen every slot; turn it into a
   // response and the new entry count.
   always_comb begin
      result             = '0;
      result.status      = olte_pkg::STATUS_OK;
      result.entry_count = last_tok.count;
      case (last_tok.op)
         olte_pkg::OP_APPEND: begin
            if (last_tok.count >= olte_pkg::COUNT_W'(olte_pkg::DEPTH)) begin
               result.status = olte_pkg::STATUS_FULL;
            end else begin
               result.entry_count = last_tok.count + olte_pkg::COUNT_W'(1);
            end
         end
         olte_pkg::OP_REMOVE: begin
            if (last_tok.hit) begin
               result.found       = 1'b1;
               result.entry_count = last_tok.count - olte_pkg::COUNT_W'(1);
            end else begin
               result.status = olte_pkg::STATUS_NOT_FOUND;
            end
         end
         olte_pkg::OP_GET: begin
            if (olte_pkg::COUNT_W'(last_tok.pos) < last_tok.count) begin
               result.read_value = olte_pkg::VALUE_W'(last_tok.rd);
            end else begin
               result.status = olte_pkg::STATUS_RANGE;
            end
         end
         olte_pkg::OP_SET: begin
            if (olte_pkg::COUNT_W'(last_tok.pos) >= last_tok.count) begin
               result.status = olte_pkg::STATUS_RANGE;
            end
         end
         olte_pkg::OP_FIND: begin
            if (last_tok.hit) begin
               result.found       = 1'b1;
               result.match_index = last_tok.match_idx;
            end else begin
               result.status = olte_pkg::STATUS_NOT_FOUND;
            end
         end
         olte_pkg::OP_CLEAR: begin
            result.entry_count = '0;
         end
         default: begin
         end
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;

   // Control: idle, token walking, or response waiting for the output slot.
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      pend_in       = pend_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         olte_pkg::ST_IDLE: begin
            if (accept) state_in = olte_pkg::ST_RUN;
         end
         olte_pkg::ST_RUN: begin
            if (last_tok.valid) begin
               fill_count_in = result.entry_count;
               if (slot_free) begin
                  rsp_data_in  = result;
                  rsp_valid_in = 1'b1;
                  state_in     = olte_pkg::ST_IDLE;
               end else begin
                  pend_in  = result;
                  state_in = olte_pkg::ST_HOLD;
               end
            end
         end
         olte_pkg::ST_HOLD: begin
            if (slot_free) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = olte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olte_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
      if (reset) begin
         state_ff      <= olte_pkg::ST_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_data_ff.status;
   assign rsp.read_value  = rsp_data_ff.read_value;
   assign rsp.found       = rsp_data_ff.found;
   assign rsp.match_index = rsp_data_ff.match_index;
   assign rsp.entry_count = rsp_data_ff.entry_count;

endmodule

FILE: rtl/olte_checker.sv
module olte_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [olte_pkg::STATUS_W-1:0] rsp_status,
   input logic [olte_pkg::VALUE_W-1:0]  rsp_read_value,
   input logic                          rsp_found,
   input logic [olte_pkg::COUNT_W-1:0]  rsp_entry_count
);

   // Only one request is in the row at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= olte_pkg::COUNT_W'(olte_pkg::DEPTH))
      else $error("entry count above capacity");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == olte_pkg::STATUS_FULL
      |-> rsp_entry_count == olte_pkg::COUNT_W'(olte_pkg::DEPTH))
      else $error("full status with room left");

   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == olte_pkg::STATUS_OK)
      else $error("found flag with error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
      && $stable(rsp_entry_count))
      else $error("stalled response beat changed");

endmodule

bind ordered_list_table_engine_unit olte_checker u_olte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_read_value  (rsp.read_value),
   .rsp_found       (rsp.found),
   .rsp_entry_count (rsp.entry_count)
);

FILE: tb/tb_ordered_list_table_engine_unit.sv
`timescale 1ns / 1ps

module tb_ordered_list_table_engine_unit;

   // The two op codes the block leaves unused; it must answer them without
   // touching the list.
   localparam logic [olte_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [olte_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;

   // Stimulus stops once this many list operations have been queued.
   localparam int LIST_OPS_WANTED = 1100;
   // The generator stays only a few requests ahead of the driver. Value and
   // index choices then follow the predicted list closely.
   localparam int BACKLOG_MAX = 4;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [olte_pkg::OP_W-1:0]  op;
      logic [olte_pkg::POS_W-1:0] pos;
      olte_pkg::entry_type        value;
   } list_cmd_type;

   logic clock;
   logic reset;

   olte_req_if req_if ();
   olte_rsp_if rsp_if ();

   ordered_list_table_engine_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // Requests waiting for the driver, and responses predicted for every
   // accepted request, oldest first.
   list_cmd_type      cmd_backlog[$];
   olte_pkg::rsp_type predicted_replies[$];

   // The testbench's own copy of the list: contents and current length.
   olte_pkg::entry_type list_mem [olte_pkg::DEPTH];
   int                  list_len;

   int  cmds_made;
   int  beats_accepted;
   int  mismatch_count;
   logic rsp_hold;

   // Driver pacing.
   int burst_left;
   int gap_left;

   // Receiver pacing.
   int stall_mode;
   int mode_left;
   int stall_left;

   always #2 clock = ~clock;

   // Every input gets a known value at time zero.
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.op      = olte_pkg::OP_APPEND;
      req_if.position = '0;
      req_if.value   = '0;
      rsp_if.ready   = 1'b0;
      rsp_hold       = 1'b0;
   end

   // Applies one request to the list copy and returns the response that the
   // block must give for it. Remove and find both look for the lowest index
   // holding the value, among the entries currently in the list only.
   function automatic olte_pkg::rsp_type apply_list_op(
         input logic [olte_pkg::OP_W-1:0] op,
         input logic [olte_pkg::POS_W-1:0] pos,
         input olte_pkg::entry_type val);
      olte_pkg::rsp_type r;
      int                hit_at;
      r      = '0;
      hit_at = -1;
      for (int i = 0; i < list_len; i++) begin
         if (hit_at < 0 && list_mem[i] == val) begin
            hit_at = i;
         end
      end
      case (op)
         olte_pkg::OP_APPEND: begin
            if (list_len >= olte_pkg::DEPTH) begin
               r.status = olte_pkg::STATUS_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         olte_pkg::OP_REMOVE: begin
            if (hit_at >= 0) begin
               // Close the gap: everything above the match moves down one.
               for (int i = hit_at; i < list_len - 1; i++) begin
                  list_mem[i] = list_mem[i + 1];
               end
               list_len--;
               r.found = 1'b1;
            end else begin
               r.status = olte_pkg::STATUS_NOT_FOUND;
            end
         end
         olte_pkg::OP_GET: begin
            if (int'(pos) < list_len) begin
               r.read_value = list_mem[pos];
            end else begin
               r.status = olte_pkg::STATUS_RANGE;
            end
         end
         olte_pkg::OP_SET: begin
            if (int'(pos) < list_len) begin
               list_mem[pos] = val;
            end else begin
               r.status = olte_pkg::STATUS_RANGE;
            end
         end
         olte_pkg::OP_FIND: begin
            if (hit_at >= 0) begin
               r.found       = 1'b1;
               r.match_index = hit_at[olte_pkg::MIDX_W-1:0];
            end else begin
               r.status = olte_pkg::STATUS_NOT_FOUND;
            end
         end
         olte_pkg::OP_CLEAR: begin
            // Storage is kept, but nothing at or above the length is visible.
            list_len = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = list_len[olte_pkg::COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // Sender. A beat moves at an edge where valid and ready are both high, and
   // it is predicted at that same edge from the values on the bus. A new
   // request is only put out once the previous one has gone. Requests come in
   // bursts; the gaps between bursts range from nothing to more than one full
   // walk along the row, so the next request shows up at any point of the
   // block's work.
   always @(posedge clock) begin
      list_cmd_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted_replies.push_back(
               apply_list_op(req_if.op, req_if.position, req_if.value));
            beats_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               nxt = cmd_backlog.pop_front();
               req_if.op       <= nxt.op;
               req_if.position <= nxt.pos;
               req_if.value    <= nxt.value;
               req_if.valid    <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 8);
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4: gap_left = 0;
                     5, 6, 7:       gap_left = $urandom_range(1, 5);
                     default:       gap_left = $urandom_range(1, 80);
                  endcase
               end else begin
                  burst_left--;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. It runs in modes that it picks at random: always
   // ready, short frequent stalls, or rarer long ones. The long hold-off below
   // overrides all of them.
   always @(posedge clock) begin
      olte_pkg::rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode = 0;
         mode_left  = 0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_replies.size() == 0) begin
               report_mismatch("response beat with no request waiting for it");
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status got %0d, want %0d",
                                            rsp_if.status, want.status));
               if (rsp_if.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value got 0x%08h, want 0x%08h",
                                            rsp_if.read_value, want.read_value));
               if (rsp_if.found !== want.found)
                  report_mismatch($sformatf("found got %0d, want %0d",
                                            rsp_if.found, want.found));
               if (rsp_if.match_index !== want.match_index)
                  report_mismatch($sformatf("match_index got %0d, want %0d",
                                            rsp_if.match_index, want.match_index));
               if (rsp_if.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d, want %0d",
                                            rsp_if.entry_count, want.entry_count));
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            case (stall_mode)
               1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
               2: if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(5, 20);
               default: begin
               end
            endcase
         end
         rsp_if.ready <= !rsp_hold && stall_left == 0;
      end
   end

   // Long hold-off. Once the run is well under way the receiver holds ready
   // low, whatever its mode. The output register and the holding register fill,
   // and the block has to refuse further requests while the sender keeps
   // offering.
   initial begin
      while (beats_accepted < 300) @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // Picks a value that is in the list when there is one, so that remove and
   // find mostly hit.
   function automatic olte_pkg::entry_type held_value();
      if (list_len == 0) return $urandom;
      return list_mem[$urandom_range(0, list_len - 1)];
   endfunction

   // Mix of held values, a small pool that produces duplicates, and wholly
   // random words.
   function automatic olte_pkg::entry_type pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return held_value();
         4, 5:       return olte_pkg::entry_type'($urandom_range(0, 7));
         default:    return $urandom;
      endcase
   endfunction

   // Index mostly inside the list, sometimes anywhere in the field.
   function automatic logic [olte_pkg::POS_W-1:0] pick_pos();
      if (list_len > 0 && $urandom_range(0, 9) < 7)
         return olte_pkg::POS_W'($urandom_range(0, list_len - 1));
      return olte_pkg::POS_W'($urandom_range(0, olte_pkg::DEPTH - 1));
   endfunction

   task automatic queue_cmd(input logic [olte_pkg::OP_W-1:0] op,
                            input logic [olte_pkg::POS_W-1:0] pos,
                            input olte_pkg::entry_type val);
      list_cmd_type c;
      while (cmd_backlog.size() >= BACKLOG_MAX) @(negedge clock);
      c.op    = op;
      c.pos   = pos;
      c.value = val;
      cmd_backlog.push_back(c);
      if (op <= olte_pkg::OP_CLEAR) cmds_made++;
   endtask

   task automatic mixed_cmd();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25)      queue_cmd(olte_pkg::OP_APPEND, pick_pos(), pick_value());
      else if (roll < 40) queue_cmd(olte_pkg::OP_REMOVE, pick_pos(), pick_value());
      else if (roll < 58) queue_cmd(olte_pkg::OP_GET, pick_pos(), $urandom);
      else if (roll < 74) queue_cmd(olte_pkg::OP_SET, pick_pos(), pick_value());
      else if (roll < 92) queue_cmd(olte_pkg::OP_FIND, pick_pos(), pick_value());
      else if (roll < 94) queue_cmd(olte_pkg::OP_CLEAR, pick_pos(), $urandom);
      else if (roll < 97) queue_cmd(OP_UNUSED_A, pick_pos(), $urandom);
      else                queue_cmd(OP_UNUSED_B, pick_pos(), $urandom);
   endtask

   // Appends until the list is full. Because the generator runs slightly
   // ahead, a few appends usually land on the full list; more are added on
   // purpose so that the full status is always seen.
   task automatic fill_list();
      while (list_len < olte_pkg::DEPTH)
         queue_cmd(olte_pkg::OP_APPEND, pick_pos(), pick_value());
      repeat ($urandom_range(2, 4))
         queue_cmd(olte_pkg::OP_APPEND, pick_pos(), pick_value());
   endtask

   initial begin
      int epoch;
      list_len       = 0;
      cmds_made      = 0;
      beats_accepted = 0;
      mismatch_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On the empty list: remove, find, get and set all fail.
      queue_cmd(olte_pkg::OP_REMOVE, 6'd0, 32'h0000_0000);
      queue_cmd(olte_pkg::OP_FIND, 6'd0, 32'hDEAD_BEEF);
      queue_cmd(olte_pkg::OP_GET, 6'd0, 32'h0000_0000);
      queue_cmd(olte_pkg::OP_SET, 6'd63, 32'hFFFF_FFFF);
      // Extreme values, with a duplicate of the all-ones word.
      queue_cmd(olte_pkg::OP_APPEND, 6'd0, 32'h0000_0000);
      queue_cmd(olte_pkg::OP_APPEND, 6'd63, 32'hFFFF_FFFF);
      queue_cmd(olte_pkg::OP_APPEND, 6'd0, 32'h1234_5678);
      queue_cmd(olte_pkg::OP_APPEND, 6'd0, 32'hFFFF_FFFF);
      queue_cmd(olte_pkg::OP_GET, 6'd0, 32'h0);
      queue_cmd(olte_pkg::OP_GET, 6'd3, 32'h0);
      queue_cmd(olte_pkg::OP_GET, 6'd4, 32'h0);
      queue_cmd(olte_pkg::OP_GET, 6'd63, 32'h0);
      // Find must report the lower of the two matching indexes.
      queue_cmd(olte_pkg::OP_FIND, 6'd0, 32'hFFFF_FFFF);
      queue_cmd(olte_pkg::OP_SET, 6'd3, 32'hA5A5_A5A5);
      queue_cmd(olte_pkg::OP_SET, 6'd63, 32'h5A5A_5A5A);
      // Remove takes the first all-ones word and shifts the rest down.
      queue_cmd(olte_pkg::OP_REMOVE, 6'd0, 32'hFFFF_FFFF);
      queue_cmd(olte_pkg::OP_GET, 6'd1, 32'h0);
      queue_cmd(olte_pkg::OP_REMOVE, 6'd0, 32'hCAFE_F00D);
      queue_cmd(OP_UNUSED_A, 6'd63, 32'hFFFF_FFFF);
      queue_cmd(OP_UNUSED_B, 6'd21, 32'h5555_5555);
      // After clear the old words stay in storage but must not be seen.
      queue_cmd(olte_pkg::OP_CLEAR, 6'd42, 32'hAAAA_AAAA);
      queue_cmd(olte_pkg::OP_GET, 6'd0, 32'h0);
      queue_cmd(olte_pkg::OP_APPEND, 6'd0, 32'h5555_5555);
      queue_cmd(olte_pkg::OP_GET, 6'd0, 32'h0);
      queue_cmd(olte_pkg::OP_FIND, 6'd0, 32'hA5A5_A5A5);

      // Random part: epochs that fill the list, drain it, or mix all ops.
      fill_list();
      while (cmds_made < LIST_OPS_WANTED) begin
         epoch = $urandom_range(0, 5);
         if (epoch == 0) begin
            fill_list();
         end else if (epoch == 1) begin
            repeat ($urandom_range(10, 60)) begin
               if ($urandom_range(0, 9) < 7)
                  queue_cmd(olte_pkg::OP_REMOVE, pick_pos(), held_value());
               else if ($urandom_range(0, 1) == 0)
                  queue_cmd(olte_pkg::OP_FIND, pick_pos(), pick_value());
               else
                  queue_cmd(olte_pkg::OP_GET, pick_pos(), $urandom);
            end
         end else begin
            repeat ($urandom_range(20, 60)) mixed_cmd();
         end
      end

      // Wait until the last request has been taken and answered, then give
      // the block one more walk of the row to show any stray beat.
      while (cmd_backlog.size() > 0 || req_if.valid) @(posedge clock);
      while (predicted_replies.size() > 0) @(posedge clock);
      repeat (olte_pkg::DEPTH + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Safety net. The slowest correct run needs well under a quarter of this.
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
